### hw/rtl/spvm_pkg.sv
`default_nettype none

package spvm_pkg;

    // Sizes of the store, of the position word and of the other fields
    localparam int unsigned SAMPLE_DEPTH_DEF = 65536;
    localparam int unsigned POS_W            = 25;
    localparam int unsigned IDX_W            = 17;
    localparam int unsigned LEN_W            = 17;
    localparam int unsigned VOL_W            = 8;
    localparam int unsigned STEP_W           = 16;
    localparam int unsigned CFG_DATA_W       = 17;
    localparam int unsigned CFG_IDX_W        = 2;

    // Position held after a stop, and the saturation limit of the advance
    localparam logic [POS_W-1:0] STOP_POS = 25'h0FF_FFFF;
    localparam logic [POS_W-1:0] POS_MAX  = 25'h1FF_FFFF;

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0]  SAMPLE_LENGTH_RST = '0;
    localparam logic [LEN_W-1:0]  LOOP_LENGTH_RST   = '0;
    localparam logic [VOL_W-1:0]  VOLUME_RST        = 8'h80;
    localparam logic [STEP_W-1:0] STEP_RST          = 16'h0100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP          = 2'd3;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_START  = 2'd1,
        CMD_RENDER = 2'd2,
        CMD_STOP   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [15:0]        address;
        logic signed [7:0]  sample_byte;
        logic [7:0]         start_offset;
        logic signed [15:0] mix_in;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] mix_out;
        logic               voice_active;
    } t_out_item;

endpackage

`default_nettype wire

### hw/rtl/sample_playback_voice_mixer_unit.sv
// An accepted input transaction passes stage 1 (store read) and stage 2 (the output register).
// One transaction per cycle unless stalled; the single-port store takes one access a cycle.
// Reset (synchronous, active low): voice inactive, position zero, volume 128, step 256,
// sample and loop length zero, pipeline empty. The sample store is not cleared; its
// entries are undefined until written.
`default_nettype none

module sample_playback_voice_mixer_unit #(
    parameter int unsigned SAMPLE_DEPTH = spvm_pkg::SAMPLE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    // Configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [spvm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [spvm_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    // Input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire spvm_pkg::t_in_item                  i_in_data,

    // Output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output spvm_pkg::t_out_item                      o_out_data
);

    localparam int unsigned AW = $clog2(SAMPLE_DEPTH);
    localparam int unsigned CW = spvm_pkg::IDX_W + 1;   // compare width for range checks
    localparam int unsigned PW = spvm_pkg::POS_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [spvm_pkg::LEN_W-1:0]  r_sample_length;
    logic [spvm_pkg::LEN_W-1:0]  r_loop_length;
    logic [spvm_pkg::VOL_W-1:0]  r_volume;
    logic [spvm_pkg::STEP_W-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_length <= spvm_pkg::SAMPLE_LENGTH_RST;
            r_loop_length   <= spvm_pkg::LOOP_LENGTH_RST;
            r_volume        <= spvm_pkg::VOLUME_RST;
            r_step          <= spvm_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spvm_pkg::REG_SAMPLE_LENGTH: r_sample_length <= i_cfg_data;
                spvm_pkg::REG_LOOP_LENGTH:   r_loop_length   <= i_cfg_data;
                spvm_pkg::REG_VOLUME:        r_volume        <= i_cfg_data[spvm_pkg::VOL_W-1:0];
                spvm_pkg::REG_STEP:          r_step          <= i_cfg_data[spvm_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // Stage 1 holds the store read data, stage 2 is the output register.
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic s2_load;
    logic in_accept;

    assign s2_load    = r_s1_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s2_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Voice state: position and playing flag, updated at accept
    // ------------------------------------------------------------------
    logic [PW-1:0] r_pos;
    logic          r_playing;
    logic [PW-1:0] n_pos;
    logic          n_playing;

    logic [PW-1:0]                end_pos;
    logic [PW-1:0]                back_len;
    logic [PW-1:0]                wrap_pos;
    logic [PW-1:0]                cur_pos;
    logic [PW:0]                  adv_pos;
    logic [spvm_pkg::IDX_W-1:0]   rd_idx;
    logic                         rd_in_range;
    logic                         at_end;
    logic                         do_render;
    logic                         wr_en;

    assign end_pos  = {r_sample_length, 8'h00};
    assign back_len = {r_loop_length, 8'h00};
    assign at_end   = (r_pos >= end_pos);
    // Step back once by the loop length, saturating at zero
    assign wrap_pos = (back_len > r_pos) ? '0 : (r_pos - back_len);
    assign cur_pos  = at_end ? wrap_pos : r_pos;
    assign adv_pos  = {1'b0, cur_pos} + {{(PW+1-spvm_pkg::STEP_W){1'b0}}, r_step};
    assign rd_idx   = cur_pos[PW-1:8];
    assign rd_in_range = ({1'b0, rd_idx} < CW'(SAMPLE_DEPTH));

    always_comb begin
        n_pos     = r_pos;
        n_playing = r_playing;
        do_render = 1'b0;
        case (i_in_data.cmd)
            spvm_pkg::CMD_START: begin
                n_pos     = {1'b0, i_in_data.start_offset, 16'h0000};
                n_playing = 1'b1;
            end
            spvm_pkg::CMD_STOP: begin
                n_pos     = spvm_pkg::STOP_POS;
                n_playing = 1'b0;
            end
            spvm_pkg::CMD_RENDER: begin
                if (r_playing) begin
                    if (at_end && (r_loop_length == '0)) begin
                        // One-shot sample ran out: stop and pass the mix through
                        n_playing = 1'b0;
                    end else begin
                        do_render = 1'b1;
                        n_pos     = adv_pos[PW] ? spvm_pkg::POS_MAX : adv_pos[PW-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_playing <= 1'b0;
        end else if (in_accept) begin
            r_pos     <= n_pos;
            r_playing <= n_playing;
        end
    end

    // ------------------------------------------------------------------
    // Sample store: one write or one read per cycle, registered read data.
    // A write lands at its accept edge, so a render in the next cycle
    // already sees it; no forwarding is needed.
    // ------------------------------------------------------------------
    logic [7:0]                  mem [SAMPLE_DEPTH];
    logic [7:0]                  r_rd_byte;
    logic [spvm_pkg::IDX_W-1:0]  wr_addr_ext;

    assign wr_addr_ext = {1'b0, i_in_data.address};
    assign wr_en = in_accept && (i_in_data.cmd == spvm_pkg::CMD_WRITE)
                   && ({2'b00, i_in_data.address} < CW'(SAMPLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr_ext[AW-1:0]] <= i_in_data.sample_byte;
        end
        if (in_accept && do_render) begin
            r_rd_byte <= mem[rd_idx[AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 side data: carry the mix and the decision along the read
    // ------------------------------------------------------------------
    logic signed [15:0] r_s1_mix;
    logic               r_s1_add;
    logic               r_s1_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_mix    <= i_in_data.mix_in;
            // An index past the store reads as zero: drop the contribution
            r_s1_add    <= do_render && rd_in_range;
            r_s1_active <= n_playing;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale the byte by the volume and add it to the mix
    // ------------------------------------------------------------------
    logic signed [16:0] prod;
    logic [15:0]        sum;

    assign prod = $signed({{9{r_rd_byte[7]}}, r_rd_byte}) * $signed({9'd0, r_volume});
    assign sum  = r_s1_mix + prod[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s2_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            o_out_data.mix_out      <= r_s1_add ? sum : r_s1_mix;
            o_out_data.voice_active <= r_s1_active;
        end
    end

endmodule

`default_nettype wire

### tb/testbench.sv
module testbench;
    import spvm_pkg::*;

    localparam int unsigned DEPTH        = SAMPLE_DEPTH_DEF;
    localparam int unsigned DEPTH_AW     = $clog2(DEPTH);
    localparam int          RANDOM_ITEMS = 1440;
    localparam int          CYCLE_LIMIT  = 600_000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          DRAIN_CYCLES  = 10;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;

    // Voice predictor state, kept in step with every transaction sent
    logic signed [7:0]   sample_mem [DEPTH];
    bit                  sample_mem_valid [DEPTH];
    logic [POS_W-1:0]    play_pos       = '0;
    bit                  voice_on       = 1'b0;
    logic [LEN_W-1:0]    cfg_sample_len = SAMPLE_LENGTH_RST;
    logic [LEN_W-1:0]    cfg_loop_len   = LOOP_LENGTH_RST;
    logic [VOL_W-1:0]    cfg_volume     = VOLUME_RST;
    logic [STEP_W-1:0]   cfg_step       = STEP_RST;

    t_out_item pending_mix_q [$];

    int error_count  = 0;
    int cycle_count  = 0;
    int items_sent   = 0;
    int tx_free_left = 0;
    int rx_free_left = 0;
    int rx_hold_req  = 0;

    sample_playback_voice_mixer_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Apply one transaction to the predictor and return the result it causes.
    function automatic t_out_item predict_voice(input t_in_item it);
        t_out_item         r;
        logic [POS_W-1:0]  back;
        logic [POS_W:0]    next_pos;
        logic [IDX_W-1:0]  idx;
        logic signed [7:0] b;
        int                sum;
        bit                advance;
        r.mix_out = it.mix_in;
        case (it.cmd)
            CMD_WRITE: begin
                if (it.address < DEPTH) begin
                    sample_mem[it.address]       = it.sample_byte;
                    sample_mem_valid[it.address] = 1'b1;
                end
            end
            CMD_START: begin
                play_pos = {1'b0, it.start_offset, 16'h0000};
                voice_on = 1'b1;
            end
            CMD_STOP: begin
                play_pos = STOP_POS;
                voice_on = 1'b0;
            end
            CMD_RENDER: begin
                if (voice_on) begin
                    advance = 1'b1;
                    // End check first: loop back once, or end a one-shot sample
                    if (play_pos >= {cfg_sample_len, 8'h00}) begin
                        if (cfg_loop_len != '0) begin
                            back     = {cfg_loop_len, 8'h00};
                            play_pos = (back > play_pos) ? '0 : play_pos - back;
                        end else begin
                            voice_on = 1'b0;
                            advance  = 1'b0;
                        end
                    end
                    if (advance) begin
                        idx       = play_pos[POS_W-1:8];
                        b         = (idx < DEPTH) ? sample_mem[idx[DEPTH_AW-1:0]] : 8'sh00;
                        sum       = int'(it.mix_in) + int'(b) * int'(cfg_volume);
                        r.mix_out = 16'(sum);
                        next_pos  = {1'b0, play_pos} + (POS_W+1)'(cfg_step);
                        play_pos  = (next_pos > {1'b0, POS_MAX}) ? POS_MAX
                                                                 : next_pos[POS_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.voice_active = voice_on;
        return r;
    endfunction

    // Tell whether a render now would read the store, and at which byte index.
    function automatic bit render_reads(output int unsigned idx);
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] back;
        idx = 0;
        if (!voice_on) return 1'b0;
        pos = play_pos;
        if (pos >= {cfg_sample_len, 8'h00}) begin
            if (cfg_loop_len == '0) return 1'b0;
            back = {cfg_loop_len, 8'h00};
            pos  = (back > pos) ? '0 : pos - back;
        end
        idx = 32'(pos[POS_W-1:8]);
        return idx < DEPTH;
    endfunction

    function automatic t_in_item random_item(input t_cmd c);
        t_in_item it;
        it.cmd          = c;
        it.address      = 16'($urandom);
        it.sample_byte  = 8'($urandom);
        it.start_offset = 8'($urandom);
        it.mix_in       = 16'($urandom);
        return it;
    endfunction

    function automatic logic signed [15:0] pick_mix();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one transaction; return at the edge where it is taken.
    task automatic send_item(input t_in_item it);
        int gap;
        if (tx_free_left > 0) begin
            gap = 0;
            tx_free_left--;
        end else begin
            gap = $urandom_range(0, 14);
            if ($urandom_range(0, 15) == 0) tx_free_left = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pending_mix_q.push_back(predict_voice(it));
        items_sent++;
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    task automatic send_write(input logic [15:0] addr, input logic signed [7:0] value);
        t_in_item it;
        it             = random_item(CMD_WRITE);
        it.address     = addr;
        it.sample_byte = value;
        send_item(it);
    endtask

    task automatic send_start(input logic [7:0] offs);
        t_in_item it;
        it              = random_item(CMD_START);
        it.start_offset = offs;
        send_item(it);
    endtask

    task automatic send_stop();
        send_item(random_item(CMD_STOP));
    endtask

    // Fill the byte a render is about to read if it was never written, then render.
    task automatic render_sample(input logic signed [15:0] mix);
        t_in_item    it;
        int unsigned idx;
        if (render_reads(idx) && !sample_mem_valid[idx[DEPTH_AW-1:0]])
            send_write(16'(idx), 8'($urandom));
        it        = random_item(CMD_RENDER);
        it.mix_in = mix;
        send_item(it);
    endtask

    // Drain the pipeline, then write one register and mirror it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_mix_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SAMPLE_LENGTH: cfg_sample_len = value[LEN_W-1:0];
            REG_LOOP_LENGTH:   cfg_loop_len   = value[LEN_W-1:0];
            REG_VOLUME:        cfg_volume     = value[VOL_W-1:0];
            REG_STEP:          cfg_step       = value[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // Stopped voice passes the mix; a start with zero length ends on the first render.
    task automatic test_reset_state();
        render_sample(16'sh8000);
        render_sample(16'sh7fff);
        send_start(8'd0);
        render_sample(16'sh1234);
        send_stop();
        render_sample(pick_mix());
    endtask

    task automatic test_directed_playback();
        write_reg(REG_SAMPLE_LENGTH, 17'd3);
        write_reg(REG_VOLUME, 17'd255);
        send_write(16'd0, 8'sh80);
        send_write(16'd1, 8'sh7f);
        send_write(16'd2, 8'shff);
        send_write(16'hffff, 8'sh7f);
        // Play three bytes at full gain with wrapping sums, then hit the one-shot end
        send_start(8'd0);
        render_sample(16'sh7fff);
        render_sample(16'sh7fff);
        render_sample(16'sh8000);
        render_sample(16'sh0000);
        render_sample(16'sh5555);
        // Loop longer than the position: step back clamps at zero
        write_reg(REG_LOOP_LENGTH, 17'h10000);
        send_start(8'd0);
        repeat (5) render_sample(pick_mix());
        // Start far past the end: one step back still leaves it past the end
        write_reg(REG_LOOP_LENGTH, 17'd1);
        send_start(8'd1);
        repeat (2) render_sample(pick_mix());
        // Last page of the store, full length, frozen position
        write_reg(REG_SAMPLE_LENGTH, 17'h10000);
        write_reg(REG_STEP, 17'd0);
        send_start(8'd255);
        render_sample(16'sh8000);
        render_sample(pick_mix());
        send_stop();
    endtask

    // Push the position past the store and into saturation of the advance.
    task automatic test_position_runaway();
        write_reg(REG_SAMPLE_LENGTH, 17'd0);
        write_reg(REG_LOOP_LENGTH, 17'd1);
        write_reg(REG_STEP, 17'hffff);
        write_reg(REG_VOLUME, 17'($urandom_range(0, 255)));
        send_start(8'd255);
        repeat (320) render_sample(pick_mix());
        send_stop();
    endtask

    // Hold the output off for a long stretch while the input keeps offering.
    task automatic test_input_backpressure();
        write_reg(REG_SAMPLE_LENGTH, 17'd64);
        write_reg(REG_LOOP_LENGTH, 17'd48);
        write_reg(REG_STEP, 17'd200);
        rx_hold_req  = 300;
        tx_free_left = 80;
        send_start(8'd0);
        repeat (60) render_sample(pick_mix());
        send_stop();
    endtask

    task automatic test_random_playback();
        int unsigned len;
        int unsigned lp;
        int          first;
        int          n;
        int          r;
        logic [7:0]  offs;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            case ($urandom_range(0, 4))
                0:       len = 0;
                1:       len = 65536;
                2:       len = $urandom_range(1, 64);
                3:       len = $urandom_range(65, 4096);
                default: len = $urandom_range(0, 65536);
            endcase
            case ($urandom_range(0, 5))
                0, 1:    lp = 0;
                2:       lp = 65536;
                3:       lp = $urandom_range(1, 64);
                4:       lp = (len == 0) ? 1 : $urandom_range(1, len);
                default: lp = $urandom_range(0, 65536);
            endcase
            write_reg(REG_SAMPLE_LENGTH, 17'(len));
            write_reg(REG_LOOP_LENGTH, 17'(lp));
            case ($urandom_range(0, 3))
                0:       write_reg(REG_VOLUME, 17'd0);
                1:       write_reg(REG_VOLUME, 17'd255);
                default: write_reg(REG_VOLUME, 17'($urandom_range(0, 255)));
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(REG_STEP, 17'd0);
                1:       write_reg(REG_STEP, 17'hffff);
                2:       write_reg(REG_STEP, 17'd256);
                3:       write_reg(REG_STEP, 17'($urandom_range(1, 512)));
                default: write_reg(REG_STEP, 17'($urandom_range(0, 65535)));
            endcase
            n = $urandom_range(10, 40);
            if ($urandom_range(0, 3) != 0) begin
                // Playback sequence: start inside the sample, mostly renders
                if ($urandom_range(0, 3) == 0)
                    offs = 8'($urandom);
                else
                    offs = 8'($urandom_range(0, (len >= 65536) ? 255 : len >> 8));
                send_start(offs);
                repeat (n) begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        send_stop();
                    else if (r == 1)
                        send_start(8'($urandom));
                    else if (r <= 3)
                        send_write(16'($urandom), 8'($urandom));
                    else
                        render_sample(pick_mix());
                end
            end else begin
                // Noise: any command in any order
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0:       send_write(16'($urandom), 8'($urandom));
                        1:       send_start(8'($urandom));
                        2:       render_sample(pick_mix());
                        default: send_stop();
                    endcase
                end
            end
        end
    endtask

    // Output side: stall a random number of cycles before each result.
    initial begin
        int n;
        forever begin
            if (rx_hold_req > 0) begin
                n           = rx_hold_req;
                rx_hold_req = 0;
            end else if (rx_free_left > 0) begin
                n = 0;
                rx_free_left--;
            end else begin
                n = $urandom_range(0, 14);
                if ($urandom_range(0, 15) == 0) rx_free_left = $urandom_range(20, 60);
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk) begin : check_result
        t_out_item want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (pending_mix_q.size() == 0) begin
                $display("%0t: unexpected result: mix_out %0d voice_active %0b",
                         $time, out_data.mix_out, out_data.voice_active);
                error_count++;
            end else begin
                want = pending_mix_q.pop_front();
                if (out_data.mix_out !== want.mix_out) begin
                    $display("%0t: mix_out mismatch: expected %0d, actual %0d",
                             $time, want.mix_out, out_data.mix_out);
                    error_count++;
                end
                if (out_data.voice_active !== want.voice_active) begin
                    $display("%0t: voice_active mismatch: expected %0b, actual %0b",
                             $time, want.voice_active, out_data.voice_active);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_mix_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_directed_playback();
        test_position_runaway();
        test_input_backpressure();
        test_random_playback();
        in_valid <= 1'b0;
        while (pending_mix_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
